// ===== design/bon_pkg.sv =====
// ---------------------------------------------------------------------------
// bon_pkg: shared types and constants of the binomial order normalizer
// Item and result layouts, sequencer states, configuration register indexes
// and the exponent saturation helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bon_pkg;

  // Sizing of the stores and the exponent range.
  localparam int MAX_VARS = 16;
  localparam int EXP_BITS = 16;

  // Fixed field widths of the interface.
  localparam int VAL_W     = 16;
  localparam int DEG_W     = 40;
  localparam int WIDX_W    = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Derived widths.
  localparam int POS_W    = $clog2(MAX_VARS + 1);
  localparam int ADDR_W   = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int LIM_BITS = (EXP_BITS > VAL_W) ? VAL_W : EXP_BITS;
  localparam int PROD_W   = 2 * VAL_W;

  // Largest magnitude an exponent or weight may carry.
  localparam logic signed [VAL_W-1:0] VAL_LIM = VAL_W'((1 << (LIM_BITS - 1)) - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_IS_REVLEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS        = 1'b1;

  // Reset values of the configuration registers.
  localparam logic             REVLEX_RESET   = 1'b1;
  localparam logic [CNT_W-1:0] NUM_VARS_RESET = CNT_W'(16);

  // Item operation codes.
  localparam logic OP_WEIGHT   = 1'b0;
  localparam logic OP_EXPONENT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [WIDX_W-1:0]        weight_index;
    logic signed [VAL_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  exponent_out;
    logic signed [DEG_W-1:0]  positive_degree;
    logic signed [DEG_W-1:0]  negative_degree;
    logic                     was_inverted;
    logic                     last_out;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Clamp a raw value into the symmetric legal range.
  function automatic logic signed [VAL_W-1:0] saturate(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > VAL_LIM) begin
      r = VAL_LIM;
    end else if (v < -VAL_LIM) begin
      r = -VAL_LIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/binomial_order_normalizer.sv =====
// ---------------------------------------------------------------------------
// binomial_order_normalizer: weighted degree order normalizer for binomials
// Loads a weight table, takes one binomial as a stream of signed exponents,
// orders its two monomials and emits the normalized binomial.
// ---------------------------------------------------------------------------
// A weight-write item (op 0) updates the weight of one variable; writes to an
// index at or above MAX_VARS are dropped. An exponent item (op 1) goes through
// the transfer, one pass through the single shared 16x16 signed multiplier
// (weight times exponent magnitude) and one 40-bit accumulate into the positive
// or negative degree. When the count of loaded exponents reaches the active
// variable count, the two degrees are compared; on a tie the tie-break scan
// walks the exponent memory from the last variable (degrevlex) or the first
// (deglex), a read and a check state per entry visited, since the memory read
// is registered. The normalized binomial is then sent one result per variable,
// each through a read and a load state, and the output side can stall it. The
// input is stalled from the cycle after an exponent transfer until that
// exponent is accumulated or, if it ends the binomial, until its last result
// has moved into the output register; that register lets the next item be
// taken while the final result still waits for its transfer. Equal monomials
// count as not normal, so they come out inverted with the degrees swapped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binomial_order_normalizer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [bon_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bon_pkg::CNT_W-1:0]           cfg_data,
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire bon_pkg::item_t                      item,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output bon_pkg::result_t                         result
);

  // Sequencer state.
  bon_pkg::state_t state;
  bon_pkg::state_t state_next;

  // Configuration registers.
  logic                         order_is_revlex;
  logic [bon_pkg::CNT_W-1:0]    num_vars;
  logic [bon_pkg::CNT_W-1:0]    active_vars;

  // Weight table: reset to zero, read only at the current load position.
  logic signed [bon_pkg::VAL_W-1:0] weight_table [bon_pkg::MAX_VARS];

  // Exponent memory with a registered read port; contents need no reset
  // because only entries written in the current binomial are ever read.
  logic signed [bon_pkg::VAL_W-1:0] exp_mem [bon_pkg::MAX_VARS];
  logic signed [bon_pkg::VAL_W-1:0] rd_data;

  // Datapath registers.
  logic signed [bon_pkg::VAL_W-1:0]  val_r;
  logic signed [bon_pkg::VAL_W-1:0]  val_mag;
  logic signed [bon_pkg::PROD_W-1:0] prod;
  logic signed [bon_pkg::DEG_W-1:0]  pos_acc;
  logic signed [bon_pkg::DEG_W-1:0]  neg_acc;
  logic [bon_pkg::POS_W-1:0]         load_pos;
  logic [bon_pkg::POS_W-1:0]         load_pos_inc;
  logic [bon_pkg::POS_W-1:0]         last_pos;
  logic [bon_pkg::ADDR_W-1:0]        last_idx;
  logic [bon_pkg::ADDR_W-1:0]        load_addr;
  logic [bon_pkg::ADDR_W-1:0]        ptr;
  logic                              normal;

  // Handshake and sequencing terms.
  logic accept;
  logic weight_wr;
  logic load_done;
  logic degrees_differ;
  logic scan_hit;
  logic scan_end;
  logic emit_last;
  logic out_free;
  logic out_load;
  logic inverted;

  // A count of zero acts as one; anything above the store depth saturates.
  always_comb begin
    if (num_vars == '0) begin
      active_vars = bon_pkg::CNT_W'(1);
    end else if (num_vars > bon_pkg::CNT_W'(bon_pkg::MAX_VARS)) begin
      active_vars = bon_pkg::CNT_W'(bon_pkg::MAX_VARS);
    end else begin
      active_vars = num_vars;
    end
  end

  assign accept       = item_valid && !item_stall;
  assign weight_wr    = accept && (item.op == bon_pkg::OP_WEIGHT) &&
                        ({1'b0, item.weight_index} < bon_pkg::CNT_W'(bon_pkg::MAX_VARS));
  assign load_pos_inc = load_pos + bon_pkg::POS_W'(1);
  assign last_pos     = load_pos - bon_pkg::POS_W'(1);
  assign last_idx     = last_pos[bon_pkg::ADDR_W-1:0];
  assign load_addr    = load_pos[bon_pkg::ADDR_W-1:0];
  // The binomial closes as soon as the loaded count reaches the current
  // count, which also covers a count lowered in the middle of a binomial.
  assign load_done    = bon_pkg::CNT_W'(load_pos_inc) >= active_vars;
  assign degrees_differ = (pos_acc != neg_acc);
  assign val_mag      = (val_r < 0) ? -val_r : val_r;

  // Degrevlex looks for the last nonzero exponent, deglex for the first.
  assign scan_hit  = (rd_data != '0);
  assign scan_end  = order_is_revlex ? (ptr == '0) : (ptr == last_idx);
  assign emit_last = (ptr == last_idx);
  assign out_free  = !result_valid || !result_stall;
  assign inverted  = !normal;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      bon_pkg::ST_IDLE: begin
        if (accept && (item.op == bon_pkg::OP_EXPONENT)) begin
          state_next = bon_pkg::ST_MUL;
        end
      end
      bon_pkg::ST_MUL: begin
        state_next = bon_pkg::ST_ACC;
      end
      bon_pkg::ST_ACC: begin
        state_next = load_done ? bon_pkg::ST_CMP : bon_pkg::ST_IDLE;
      end
      bon_pkg::ST_CMP: begin
        state_next = degrees_differ ? bon_pkg::ST_EMIT_RD : bon_pkg::ST_SCAN_RD;
      end
      bon_pkg::ST_SCAN_RD: begin
        state_next = bon_pkg::ST_SCAN_CHK;
      end
      bon_pkg::ST_SCAN_CHK: begin
        state_next = (scan_hit || scan_end) ? bon_pkg::ST_EMIT_RD : bon_pkg::ST_SCAN_RD;
      end
      bon_pkg::ST_EMIT_RD: begin
        state_next = bon_pkg::ST_EMIT_LD;
      end
      bon_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          state_next = emit_last ? bon_pkg::ST_IDLE : bon_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = bon_pkg::ST_IDLE;
      end
    endcase
  end

  // State-decoded outputs.
  always_comb begin
    item_stall = (state != bon_pkg::ST_IDLE);
    out_load   = (state == bon_pkg::ST_EMIT_LD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bon_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_is_revlex <= bon_pkg::REVLEX_RESET;
      num_vars        <= bon_pkg::NUM_VARS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bon_pkg::CFG_ORDER_IS_REVLEX: order_is_revlex <= cfg_data[0];
        bon_pkg::CFG_NUM_VARS:        num_vars        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Weight table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bon_pkg::MAX_VARS; i++) begin
        weight_table[i] <= '0;
      end
    end else if (weight_wr) begin
      weight_table[item.weight_index[bon_pkg::ADDR_W-1:0]] <= bon_pkg::saturate(item.value);
    end
  end

  // Exponent memory: written during the multiply cycle, read every cycle
  // at the scan or emit pointer.
  always_ff @(posedge clk) begin
    if (state == bon_pkg::ST_MUL) begin
      exp_mem[load_addr] <= val_r;
    end
    rd_data <= exp_mem[ptr];
  end

  // Operand capture and the shared multiplier.
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r <= bon_pkg::saturate(item.value);
    end
    if (state == bon_pkg::ST_MUL) begin
      prod <= weight_table[load_addr] * val_mag;
    end
  end

  // Accumulators, load position, pointer and order decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_acc  <= '0;
      neg_acc  <= '0;
      load_pos <= '0;
      ptr      <= '0;
      normal   <= 1'b0;
    end else begin
      case (state)
        bon_pkg::ST_ACC: begin
          if (val_r > 0) begin
            pos_acc <= pos_acc + bon_pkg::DEG_W'(prod);
          end else if (val_r < 0) begin
            neg_acc <= neg_acc + bon_pkg::DEG_W'(prod);
          end
          load_pos <= load_pos_inc;
        end
        bon_pkg::ST_CMP: begin
          // A lower negative degree means the binomial is already normal.
          normal <= (neg_acc < pos_acc);
          if (!degrees_differ && order_is_revlex) begin
            ptr <= last_idx;
          end else begin
            ptr <= '0;
          end
        end
        bon_pkg::ST_SCAN_CHK: begin
          if (scan_hit) begin
            normal <= order_is_revlex ? (rd_data < 0) : (rd_data > 0);
            ptr    <= '0;
          end else if (scan_end) begin
            // Both monomials are equal: not strictly smaller.
            normal <= 1'b0;
            ptr    <= '0;
          end else if (order_is_revlex) begin
            ptr <= ptr - bon_pkg::ADDR_W'(1);
          end else begin
            ptr <= ptr + bon_pkg::ADDR_W'(1);
          end
        end
        bon_pkg::ST_EMIT_LD: begin
          if (out_load) begin
            if (emit_last) begin
              ptr      <= '0;
              load_pos <= '0;
              pos_acc  <= '0;
              neg_acc  <= '0;
            end else begin
              ptr <= ptr + bon_pkg::ADDR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.exponent_out    <= inverted ? -rd_data : rd_data;
      result.positive_degree <= inverted ? neg_acc : pos_acc;
      result.negative_degree <= inverted ? pos_acc : neg_acc;
      result.was_inverted    <= inverted;
      result.last_out        <= emit_last;
    end
  end

  // The load position never runs past the depth of the exponent memory.
  assert property (@(posedge clk) disable iff (rst)
    load_pos <= bon_pkg::POS_W'(bon_pkg::MAX_VARS))
    else $error("load position beyond exponent memory depth");

  // A comparison only starts once at least one exponent has been loaded.
  assert property (@(posedge clk) disable iff (rst)
    (state == bon_pkg::ST_CMP) |-> (load_pos != '0))
    else $error("comparison started with an empty binomial");

  // Scan and emit pointers stay within the loaded binomial.
  assert property (@(posedge clk) disable iff (rst)
    (state == bon_pkg::ST_SCAN_CHK || state == bon_pkg::ST_EMIT_LD) |->
      (bon_pkg::POS_W'(ptr) < load_pos))
    else $error("pointer outside the loaded binomial");

  // Sending the final result clears the binomial state for the next one.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_last) |=>
      (load_pos == '0 && pos_acc == '0 && neg_acc == '0 && state == bon_pkg::ST_IDLE))
    else $error("binomial state not cleared after final result");

endmodule

`default_nettype wire

// ===== bench/bon_order_check.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bon_order_check: prediction and comparison for the binomial order normalizer
// Follows configuration writes and item transfers, keeps its own copy of the
// weight table and the binomial being loaded, and works out the normalized
// terms of every finished binomial. Each result transfer is compared field by
// field with the oldest predicted term.
// ---------------------------------------------------------------------------

module bon_order_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bon_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bon_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  bon_pkg::item_t                item,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  bon_pkg::result_t              result,
  output int                            fail_total,
  output int                            in_flight
);

  import bon_pkg::*;

  logic signed [VAL_W-1:0] weight_mem [MAX_VARS];
  logic signed [VAL_W-1:0] exp_mem [MAX_VARS];
  int unsigned             loaded;
  logic signed [DEG_W-1:0] pos_deg;
  logic signed [DEG_W-1:0] neg_deg;
  logic                    tie_revlex;
  logic [CNT_W-1:0]        var_limit;
  result_t                 normalized_terms [$];
  int                      mismatch_count;

  // Weights and exponents are held to the symmetric range.
  function automatic logic signed [VAL_W-1:0] clip_value(input logic signed [VAL_W-1:0] raw);
    logic signed [VAL_W-1:0] v;
    v = raw;
    if (raw > VAL_LIM) begin
      v = VAL_LIM;
    end else if (raw < -VAL_LIM) begin
      v = -VAL_LIM;
    end
    return v;
  endfunction

  task automatic advance_binomial(input item_t it);
    logic signed [VAL_W-1:0]  v;
    logic signed [VAL_W-1:0]  mag;
    logic signed [PROD_W-1:0] prod;
    int unsigned              active;
    logic                     normal;
    logic                     found;
    result_t                  term;
    v = clip_value(it.value);
    if (it.op == OP_WEIGHT) begin
      if (it.weight_index < MAX_VARS) begin
        weight_mem[it.weight_index[ADDR_W-1:0]] = v;
      end
    end else begin
      exp_mem[loaded] = v;
      mag = (v < 0) ? -v : v;
      prod = weight_mem[loaded] * mag;
      if (v > 0) begin
        pos_deg = pos_deg + prod;
      end else if (v < 0) begin
        neg_deg = neg_deg + prod;
      end
      loaded++;
      active = (var_limit == 0) ? 1 : ((var_limit > MAX_VARS) ? MAX_VARS : var_limit);
      if (loaded >= active) begin
        // The negative monomial must be strictly smaller for the binomial to stand.
        normal = 1'b0;
        found = 1'b0;
        if (neg_deg != pos_deg) begin
          normal = neg_deg < pos_deg;
        end else if (tie_revlex) begin
          for (int k = loaded; k > 0; k--) begin
            if (!found && exp_mem[k-1] != 0) begin
              normal = exp_mem[k-1] < 0;
              found = 1'b1;
            end
          end
        end else begin
          for (int k = 0; k < loaded; k++) begin
            if (!found && exp_mem[k] != 0) begin
              normal = exp_mem[k] > 0;
              found = 1'b1;
            end
          end
        end
        for (int k = 0; k < loaded; k++) begin
          term.exponent_out    = normal ? exp_mem[k] : -exp_mem[k];
          term.positive_degree = normal ? pos_deg : neg_deg;
          term.negative_degree = normal ? neg_deg : pos_deg;
          term.was_inverted    = !normal;
          term.last_out        = (k == loaded - 1);
          normalized_terms = {normalized_terms, term};
        end
        loaded = 0;
        pos_deg = '0;
        neg_deg = '0;
      end
    end
  endtask

  task automatic check_term(input result_t got);
    result_t want;
    if (normalized_terms.size() == 0) begin
      $error("result transfer with no term outstanding: exponent_out %0d",
             got.exponent_out);
      mismatch_count++;
    end else begin
      want = normalized_terms.pop_front();
      if (got.exponent_out !== want.exponent_out) begin
        $error("exponent_out: expected %0d, got %0d", want.exponent_out, got.exponent_out);
        mismatch_count++;
      end
      if (got.positive_degree !== want.positive_degree) begin
        $error("positive_degree: expected %0d, got %0d",
               want.positive_degree, got.positive_degree);
        mismatch_count++;
      end
      if (got.negative_degree !== want.negative_degree) begin
        $error("negative_degree: expected %0d, got %0d",
               want.negative_degree, got.negative_degree);
        mismatch_count++;
      end
      if (got.was_inverted !== want.was_inverted) begin
        $error("was_inverted: expected %0b, got %0b", want.was_inverted, got.was_inverted);
        mismatch_count++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_VARS; k++) begin
        weight_mem[k] = '0;
        exp_mem[k] = '0;
      end
      loaded = 0;
      pos_deg = '0;
      neg_deg = '0;
      tie_revlex = REVLEX_RESET;
      var_limit = NUM_VARS_RESET;
      normalized_terms.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_ORDER_IS_REVLEX) begin
          tie_revlex = cfg_data[0];
        end else if (cfg_index == CFG_NUM_VARS) begin
          var_limit = cfg_data;
        end
      end
      if (item_valid && !item_stall) begin
        advance_binomial(item);
      end
      if (result_valid && !result_stall) begin
        check_term(result);
      end
    end
    fail_total <= mismatch_count;
    in_flight <= normalized_terms.size();
  end

endmodule

// ===== bench/binomial_order_normalizer_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binomial_order_normalizer_tb: stimulus and verdict for the order normalizer
// Drives weight writes, binomial exponent streams and register writes, with
// random gaps on the sender and random stalls on the receiver. A separate
// checker predicts every normalized term and reports mismatches; this module
// only produces traffic and decides pass or fail.
// ---------------------------------------------------------------------------

module binomial_order_normalizer_tb;

  import bon_pkg::*;

  // Random items wanted after the directed part.
  localparam int RANDOM_ITEMS  = 255;
  // An exponent item keeps the block busy through its multiply and accumulate
  // states after its transfer and a weight write not at all, so this is ample
  // before a register write once no term is outstanding.
  localparam int SETTLE_CYCLES = 12;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES   = 300;
  // Quiet cycles tolerated before the run is declared hung. The longest
  // correct quiet spell is the hold-off above plus a settle, far below this.
  localparam int QUIET_LIMIT   = 2000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  int   fail_total;
  int   in_flight;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  logic tx_eager = 1'b0;      // sender offers back to back when set
  logic rx_eager = 1'b0;      // receiver never stalls on its own when set
  logic hold_request = 1'b0;  // one-cycle pulse that starts the long hold-off
  int   rx_wait = 0;
  int   hold_left = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  binomial_order_normalizer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  bon_order_check order_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_total   (fail_total),
    .in_flight    (in_flight)
  );

  // Receiver. After each result transfer it draws how many cycles to stall
  // before taking the next one. On request it holds off for a long stretch,
  // counted here, so that the block fills up and stalls its own input.
  always @(posedge clk) begin : receiver
    int draw;
    if (rst) begin
      result_stall <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (result_valid && !result_stall) begin
      draw = rx_eager ? 0 : $urandom_range(0, 4);
      rx_wait <= draw;
      result_stall <= (draw != 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      result_stall <= (rx_wait > 1);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Watchdog: any cycle without a transfer on either channel counts as quiet.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("binomial_order_normalizer_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item after a random gap and returns at the edge of its
  // transfer. Valid stays high so that a following item with no gap goes
  // out back to back.
  task automatic offer(input logic op, input logic [WIDX_W-1:0] idx,
                       input logic signed [VAL_W-1:0] val);
    int    gap;
    item_t next_item;
    gap = tx_eager ? 0 : $urandom_range(0, 4);
    next_item.op = op;
    next_item.weight_index = idx;
    next_item.value = val;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= next_item;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drops valid and waits until every predicted term has been taken and the
  // block has had time to finish any item that produces no output.
  task automatic quiesce();
    item_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly values close to zero so that degree ties happen often, then any
  // 16-bit pattern, then the range limits, the one value that saturates or zero.
  function automatic logic signed [VAL_W-1:0] draw_value(input int reach);
    int                      pick;
    int                      near;
    logic signed [VAL_W-1:0] v;
    pick = $urandom_range(0, 19);
    near = $urandom_range(0, 2 * reach);
    if (pick < 11) begin
      v = VAL_W'(near - reach);
    end else if (pick < 17) begin
      v = VAL_W'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0: v = VAL_LIM;
        1: v = -VAL_LIM;
        2: v = 16'sh8000;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  // Weight slots mostly inside the table; a quarter anywhere in the index
  // field, so writes beyond the table are dropped now and then.
  function automatic logic [WIDX_W-1:0] draw_slot();
    logic [WIDX_W-1:0] s;
    if ($urandom_range(0, 3) == 0) begin
      s = WIDX_W'($urandom_range(0, 63));
    end else begin
      s = WIDX_W'($urandom_range(0, MAX_VARS - 1));
    end
    return s;
  endfunction

  initial begin : stimulus
    int goal;
    int phase;
    int pick;
    int count_cfg;
    int span;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Reset settings first: degrevlex with 16 variables.
    // Weights at both range limits; -32768 must saturate to -32767. The two
    // writes beyond the table must leave it alone, including slot 0 that a
    // truncated index would hit.
    offer(OP_WEIGHT, 6'd0, 16'sd32767);
    offer(OP_WEIGHT, 6'd1, 16'sh8000);
    offer(OP_WEIGHT, 6'd63, 16'sd1234);
    offer(OP_WEIGHT, 6'd16, -16'sd1);
    quiesce();

    // A variable count of zero acts as one: a single saturated exponent.
    write_reg(CFG_NUM_VARS, CNT_W'(0));
    offer(OP_EXPONENT, WIDX_W'($urandom_range(0, 63)), 16'sh8000);
    quiesce();

    // Three variables. The zero binomial has equal monomials and so comes
    // out inverted with the degrees swapped.
    write_reg(CFG_NUM_VARS, CNT_W'(3));
    repeat (3) offer(OP_EXPONENT, WIDX_W'($urandom_range(0, 63)), '0);

    // The two weights cancel, so the degrees tie and degrevlex decides on
    // the last nonzero exponent.
    offer(OP_EXPONENT, 6'd0, 16'sd1);
    offer(OP_EXPONENT, 6'd0, 16'sd1);
    offer(OP_EXPONENT, 6'd0, -16'sd5);
    quiesce();

    // Same kind of tie under deglex, decided by the first nonzero exponent.
    write_reg(CFG_ORDER_IS_REVLEX, CNT_W'(0));
    offer(OP_EXPONENT, 6'd0, -16'sd3);
    offer(OP_EXPONENT, 6'd0, -16'sd3);
    offer(OP_EXPONENT, 6'd0, 16'sd9);
    quiesce();

    // A count above the table size saturates. A weight write in the middle
    // of the binomial must not disturb it. Then the count shrinks below the
    // four loaded exponents, so the next exponent ends a five-term binomial.
    write_reg(CFG_NUM_VARS, CNT_W'(64));
    offer(OP_EXPONENT, 6'd0, 16'sd32767);
    offer(OP_EXPONENT, 6'd0, -16'sd2);
    offer(OP_EXPONENT, 6'd0, '0);
    offer(OP_WEIGHT, 6'd4, -16'sd32767);
    offer(OP_EXPONENT, 6'd0, 16'sd5);
    quiesce();
    write_reg(CFG_NUM_VARS, CNT_W'(2));
    offer(OP_EXPONENT, 6'd0, -16'sd7);

    // Random part, in phases. Each phase picks the registers, loads some
    // weights and sends a few well-formed binomials with random content,
    // with stray weight writes mixed in and now and then a binomial that is
    // cut short by lowering the count in its middle.
    goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      quiesce();
      write_reg(CFG_ORDER_IS_REVLEX, CNT_W'($urandom_range(0, 1)));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        count_cfg = $urandom_range(1, 5);
      end else if (pick == 6) begin
        count_cfg = MAX_VARS;
      end else if (pick == 7) begin
        count_cfg = 0;
      end else if (pick == 8) begin
        count_cfg = $urandom_range(MAX_VARS + 1, 127);
      end else begin
        count_cfg = $urandom_range(6, MAX_VARS - 1);
      end
      write_reg(CFG_NUM_VARS, CNT_W'(count_cfg));
      span = (count_cfg == 0) ? 1 : ((count_cfg > MAX_VARS) ? MAX_VARS : count_cfg);
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager <= ($urandom_range(0, 3) == 0);

      // Clearing every weight makes each binomial a degree tie, which
      // drives the tie-break scan hard.
      if ($urandom_range(0, 3) == 0) begin
        for (int k = 0; k < MAX_VARS; k++) begin
          offer(OP_WEIGHT, WIDX_W'(k), '0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) offer(OP_WEIGHT, draw_slot(), draw_value(4));
      end

      // Once, the receiver holds off while the sender keeps going full rate.
      if (phase == 1) begin
        tx_eager = 1'b1;
        item_valid <= 1'b0;
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
      end

      repeat ($urandom_range(2, 5)) begin
        for (int k = 0; k < span; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            offer(OP_WEIGHT, draw_slot(), draw_value(4));
          end
          offer(OP_EXPONENT, WIDX_W'($urandom_range(0, 63)), draw_value(3));
        end
      end

      if (span > 2 && $urandom_range(0, 3) == 0) begin
        offer(OP_EXPONENT, WIDX_W'($urandom_range(0, 63)), draw_value(3));
        offer(OP_EXPONENT, WIDX_W'($urandom_range(0, 63)), draw_value(3));
        quiesce();
        write_reg(CFG_NUM_VARS, CNT_W'(1));
        offer(OP_EXPONENT, WIDX_W'($urandom_range(0, 63)), draw_value(3));
      end
      phase++;
    end

    // Drain: every predicted term must arrive, then the verdict.
    quiesce();
    if (fail_total == 0 && in_flight == 0) begin
      $display("binomial_order_normalizer_tb OK");
    end else begin
      $display("binomial_order_normalizer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bon_pkg.sv
design/binomial_order_normalizer.sv
bench/bon_order_check.sv
bench/binomial_order_normalizer_tb.sv
